// ===== rtl/core/mkte_pkg.sv =====
// Package for the multi-tap keypad text entry block.
// Holds the keypad letter tables, mode codes and register indexes.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package mkte_pkg;

   // Register indexes on the csr port
   localparam logic CSR_ENTRY_MODE     = 1'b0;
   localparam logic CSR_COMMIT_TIMEOUT = 1'b1;

   // Entry mode codes; the unused code behaves as lower case
   localparam logic [1:0] MODE_LOWER   = 2'd0;
   localparam logic [1:0] MODE_UPPER   = 2'd1;
   localparam logic [1:0] MODE_NUMERIC = 2'd2;

   // Function codes of an input word
   localparam logic FUNC_KEY  = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   localparam logic [7:0]  ASCII_ZERO      = 8'h30;
   localparam logic [7:0]  CASE_OFFSET     = 8'd32;
   localparam logic [3:0]  LAST_DIGIT      = 4'd9;
   localparam logic [3:0]  PUNCT_DIGIT     = 4'd0;
   localparam logic [3:0]  SPACE_DIGIT     = 4'd9;
   localparam logic [15:0] TIMEOUT_RESET   = 16'd1000;

   // Number of letters on each key
   function automatic logic [3:0] group_len(input logic [3:0] digit);
      logic [3:0] len;
      case (digit)
         4'd0:    len = 4'd12;
         4'd6:    len = 4'd4;
         4'd8:    len = 4'd4;
         4'd9:    len = 4'd2;
         default: len = 4'd3;
      endcase
      return len;
   endfunction

   // Letter at a position of a key's group (lower case)
   function automatic logic [7:0] group_char(input logic [3:0] digit,
                                             input logic [3:0] pos);
      logic [7:0] ch;
      ch = 8'h00;
      case (digit)
         4'd0: begin
            case (pos)
               4'd0:    ch = ".";
               4'd1:    ch = ",";
               4'd2:    ch = "-";
               4'd3:    ch = "?";
               4'd4:    ch = "!";
               4'd5:    ch = 8'h27;
               4'd6:    ch = "@";
               4'd7:    ch = ":";
               4'd8:    ch = ";";
               4'd9:    ch = "/";
               4'd10:   ch = "(";
               4'd11:   ch = ")";
               default: ch = ".";
            endcase
         end
         4'd9: begin
            case (pos)
               4'd1:    ch = 8'h0A;
               default: ch = " ";
            endcase
         end
         4'd6: ch = 8'(8'h70 + {4'd0, pos});
         4'd7: ch = 8'(8'h74 + {4'd0, pos});
         4'd8: ch = 8'(8'h77 + {4'd0, pos});
         default: begin
            // keys 1..5 hold three consecutive letters from 'a'
            ch = 8'(8'h61 + 8'(({4'd0, digit} - 8'd1) * 8'd3) + {4'd0, pos});
         end
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mkte_req_if.sv =====
// Request channel interface: one key press or timer tick per word.
// Valid/ready handshake; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface mkte_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] key_code;

   modport source (output valid, output func, output key_code, input ready);
   modport sink   (input valid, input func, input key_code, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mkte_rsp_if.sv =====
// Response channel interface: one committed character per word.
// Valid/ready handshake; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface mkte_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       from_timeout;

   modport source (output valid, output character, output from_timeout, input ready);
   modport sink   (input valid, input character, input from_timeout, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/multitap_keypad_text_entry.sv =====
// Multi-tap keypad text entry: top level.
// Depends on mkte_pkg, mkte_req_if and mkte_rsp_if.
//
//   channel   dir  payload                     handshake
//   req_if    in   func, key_code              valid/ready
//   rsp_if    out  character, from_timeout     valid/ready
//   csr       in   csr_index, csr_write_data   csr_write_enable
//
// One word per cycle unless the response is held: an input register, then
// one pass of table lookup and countdown update into the response register.
// Reset (synchronous) clears all control and pending state and loads the
// register defaults. A held response stalls the processing stage;
// req_if.ready then drops once the input register is full.
`timescale 1ns / 1ps
`default_nettype none

module multitap_keypad_text_entry
   import mkte_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   mkte_req_if.sink         req_if,
   mkte_rsp_if.source       rsp_if,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_write_data
);

   // Configuration registers
   logic [1:0]  entry_mode_ff;
   logic [15:0] timeout_ff;

   // Input register
   logic        in_valid_ff;
   logic        in_func_ff;
   logic [7:0]  in_key_ff;

   // Pending letter state
   logic        pend_valid_ff, pend_valid_in;
   logic [3:0]  pend_digit_ff, pend_digit_in;
   logic [3:0]  letter_pos_ff, letter_pos_in;
   logic [15:0] countdown_ff,  countdown_in;

   // Response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_char_ff,  rsp_char_in;
   logic        rsp_tmo_ff,   rsp_tmo_in;

   logic        proc_go;
   logic        is_digit;
   logic [3:0]  key_digit;
   logic [3:0]  sel_digit;
   logic [3:0]  sel_pos;
   logic [7:0]  base_char;
   logic [7:0]  pend_char;
   logic [3:0]  pos_next;
   logic [15:0] restart_count;

   // Processing advances whenever the response register can take a word
   assign proc_go      = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = !in_valid_ff || proc_go;

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.character    = rsp_char_ff;
   assign rsp_if.from_timeout = rsp_tmo_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_mode_ff <= MODE_LOWER;
         timeout_ff    <= TIMEOUT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ENTRY_MODE:     entry_mode_ff <= csr_write_data[1:0];
            CSR_COMMIT_TIMEOUT: timeout_ff    <= csr_write_data;
            default:            ;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
      if (req_if.ready && req_if.valid) begin
         in_func_ff <= req_if.func;
         in_key_ff  <= req_if.key_code;
      end
   end

   // Decode of the registered key
   assign is_digit  = (in_key_ff[7:4] == ASCII_ZERO[7:4]) && (in_key_ff[3:0] <= LAST_DIGIT);
   assign key_digit = in_key_ff[3:0];

   // Character of the pending letter, with case applied at commit
   assign sel_digit = (pend_digit_ff > LAST_DIGIT) ? PUNCT_DIGIT : pend_digit_ff;
   assign sel_pos   = (letter_pos_ff >= group_len(sel_digit)) ? 4'd0 : letter_pos_ff;
   assign base_char = group_char(sel_digit, sel_pos);
   assign pend_char = (entry_mode_ff == MODE_UPPER && sel_digit != PUNCT_DIGIT &&
                       sel_digit != SPACE_DIGIT) ? 8'(base_char - CASE_OFFSET) : base_char;

   // Next letter on a repeated press, wrapping within the group
   assign pos_next = (4'(letter_pos_ff + 4'd1) >= group_len(key_digit)) ? 4'd0
                                                                       : 4'(letter_pos_ff + 4'd1);
   assign restart_count = (timeout_ff == 16'd0) ? 16'd1 : timeout_ff;

   // One pass over the registered word
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_digit_in = pend_digit_ff;
      letter_pos_in = letter_pos_ff;
      countdown_in  = countdown_ff;
      rsp_valid_in  = 1'b0;
      rsp_char_in   = pend_char;
      rsp_tmo_in    = 1'b0;
      if (in_valid_ff) begin
         if (in_func_ff == FUNC_TICK) begin
            if (pend_valid_ff) begin
               if (countdown_ff <= 16'd1) begin
                  rsp_valid_in  = 1'b1;
                  rsp_tmo_in    = 1'b1;
                  countdown_in  = 16'd0;
                  pend_valid_in = 1'b0;
                  letter_pos_in = 4'd0;
               end else begin
                  countdown_in = 16'(countdown_ff - 16'd1);
               end
            end
         end else if (is_digit) begin
            if (entry_mode_ff == MODE_NUMERIC) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = in_key_ff;
            end else begin
               if (pend_valid_ff && pend_digit_ff == key_digit) begin
                  letter_pos_in = pos_next;
               end else begin
                  rsp_valid_in  = pend_valid_ff;
                  letter_pos_in = 4'd0;
               end
               pend_digit_in = key_digit;
               pend_valid_in = 1'b1;
               countdown_in  = restart_count;
            end
         end
      end
   end

   // Pending state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         pend_digit_ff <= 4'd0;
         letter_pos_ff <= 4'd0;
         countdown_ff  <= 16'd0;
         rsp_valid_ff  <= 1'b0;
      end else if (proc_go) begin
         pend_valid_ff <= pend_valid_in;
         pend_digit_ff <= pend_digit_in;
         letter_pos_ff <= letter_pos_in;
         countdown_ff  <= countdown_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      if (proc_go && rsp_valid_in) begin
         rsp_char_ff <= rsp_char_in;
         rsp_tmo_ff  <= rsp_tmo_in;
      end
   end

`ifndef ASSERT_OFF
   // Nothing pending means the countdown and letter position are idle
   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      !pend_valid_ff |-> (countdown_ff == 16'd0 && letter_pos_ff == 4'd0))
      else $error("idle pending state not cleared");

   // A pending letter always has time left on its countdown
   a_pend_count: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> countdown_ff != 16'd0)
      else $error("pending letter with expired countdown");

   // The pending key is a digit and the position lies inside its group
   a_pend_pos: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (pend_digit_ff <= LAST_DIGIT &&
                         letter_pos_ff < group_len(pend_digit_ff)))
      else $error("pending letter position out of range");

   // A held response freezes the pending state
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_if.ready) |=>
         ($stable(countdown_ff) && $stable(pend_valid_ff) && $stable(letter_pos_ff)))
      else $error("pending state moved during response stall");
`endif

endmodule

`default_nettype wire
